>>> rtl/core/mbs_pkg.sv
package mbs_pkg;

    localparam int COIL_COUNT_DEF      = 20;
    localparam int DISCRETE_COUNT_DEF  = 10;
    localparam int INPUT_REG_COUNT_DEF = 3;
    localparam int HOLDING_COUNT_DEF   = 5;
    localparam int FRAME_BYTES_DEF     = 128;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] COIL_ON   = 16'hFF00;
    localparam logic [15:0] COIL_OFF  = 16'h0000;
    localparam logic [7:0]  EXC_FLAG  = 8'h80;

    localparam logic [7:0] FN_READ_COILS     = 8'h01;
    localparam logic [7:0] FN_READ_DISCRETE  = 8'h02;
    localparam logic [7:0] FN_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FN_READ_INPUT     = 8'h04;
    localparam logic [7:0] FN_WRITE_COIL     = 8'h05;
    localparam logic [7:0] FN_WRITE_REG      = 8'h06;
    localparam logic [7:0] FN_WRITE_COILS    = 8'h0F;
    localparam logic [7:0] FN_WRITE_REGS     = 8'h10;

    localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;
    localparam logic [7:0] EXC_DEVICE_FAILURE   = 8'h04;

    localparam int HDR_BYTES  = 6;
    localparam int PARAM_BASE = 7;
    localparam int MIN_FRAME  = 4;
    localparam int CNT_W      = 6;
    localparam int MAX_BITS   = 128;

    localparam logic [15:0] INPUT_INIT [3] = '{16'h1234, 16'h5678, 16'hABCD};
    localparam logic [15:0] HOLDING_INIT [5] =
        '{16'h1122, 16'h3344, 16'h5566, 16'h7788, 16'h9900};

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } mbs_req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } mbs_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_CAP,
        ST_DECIDE,
        ST_WR_RD,
        ST_WR_DO,
        ST_EMIT,
        ST_CRC_LO,
        ST_CRC_HI
    } mbs_state_t;

    typedef enum logic [1:0] {
        RSP_EXC,
        RSP_ECHO,
        RSP_BITS,
        RSP_WORDS
    } mbs_kind_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [MAX_BITS-1:0] coil_reset_bits();
        logic [MAX_BITS-1:0] v;
        v = '0;
        v[1]  = 1'b1;
        v[6]  = 1'b1;
        v[11] = 1'b1;
        v[16] = 1'b1;
        return v;
    endfunction

    function automatic logic [MAX_BITS-1:0] discrete_reset_bits();
        logic [MAX_BITS-1:0] v;
        v = '0;
        v[0] = 1'b1;
        v[4] = 1'b1;
        v[9] = 1'b1;
        return v;
    endfunction

endpackage

>>> rtl/core/mbs_ram.sv
module mbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/modbus_rtu_slave_engine.sv
// Modbus RTU slave. Each received byte is taken on start while busy is low and written to the
// frame buffer RAM while the frame CRC is updated. A byte marked end_of_frame raises busy
// while the frame is executed: six header reads (read, then capture state), a parameter sweep
// for multiple writes (read, then write state per data byte), then one response byte per cycle
// on rsp with rsp_valid, ending with the CRC low then high byte and last_byte set.
// The response cannot be stalled. A frame of under 4 stored bytes is dropped with no response
// and busy stays low. The frame buffer RAM read port sets the pace of the header and parameter reads.
module modbus_rtu_slave_engine #(
    parameter int COIL_COUNT      = mbs_pkg::COIL_COUNT_DEF,
    parameter int DISCRETE_COUNT  = mbs_pkg::DISCRETE_COUNT_DEF,
    parameter int INPUT_REG_COUNT = mbs_pkg::INPUT_REG_COUNT_DEF,
    parameter int HOLDING_COUNT   = mbs_pkg::HOLDING_COUNT_DEF,
    parameter int FRAME_BYTES     = mbs_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mbs_pkg::mbs_req_t req,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    output logic              rsp_valid,
    output mbs_pkg::mbs_rsp_t rsp
);

    import mbs_pkg::*;

    localparam int BUF_AW = $clog2(FRAME_BYTES);
    localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
    localparam int IR_AW  = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;
    localparam int HR_AW  = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;

    localparam logic [MAX_BITS-1:0] COIL_RST = coil_reset_bits();
    localparam logic [MAX_BITS-1:0] DISC_RST = discrete_reset_bits();

    mbs_state_t state_reg, state_next;
    logic [7:0]       slave_address_reg;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [15:0]      rx_crc_reg, rx_crc_next;
    logic             crc_ok_reg, crc_ok_next;
    logic [7:0]       hdr_reg [HDR_BYTES];
    logic             hdr_we;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mbs_kind_t        kind_reg, kind_next;
    logic [7:0]       code_reg, code_next;
    logic [CNT_W-1:0] blen_reg, blen_next;
    logic             src_reg, src_next;
    logic [7:0]       fn_reg, fn_next;
    logic [CNT_W-1:0] wtot_reg, wtot_next;
    logic [15:0]      tx_crc_reg, tx_crc_next;
    logic [7:0]       hi_reg, hi_next;
    logic             zero_reg, zero_next;

    logic [COIL_COUNT-1:0] coil_reg;
    logic [15:0]           hold_reg [HOLDING_COUNT];
    logic [DISCRETE_COUNT-1:0] disc_bits;

    logic             coil_we;
    logic [7:0]       coil_p;
    logic [7:0]       coil_mask;
    logic [7:0]       coil_d;
    logic             hold_we;
    logic [5:0]       hold_idx;
    logic [15:0]      hold_d;

    logic             ram_we;
    logic [BUF_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata;

    logic             accept;
    logic             store_byte;
    logic [15:0]      crc_byte;
    logic [LEN_W-1:0] stored_len;
    logic [15:0]      addr_f, qty_f;
    logic [16:0]      a_plus_q;
    logic [7:0]       body_byte;
    logic [CNT_W-1:0] m_idx;
    logic [7:0]       bit_p;
    logic [8:0]       bit_rem;
    logic [7:0]       bit_mask;
    logic [COIL_COUNT+7:0]     coil_wide;
    logic [DISCRETE_COUNT+7:0] disc_wide;
    logic [7:0]       bits_byte;
    logic [5:0]       word_idx;
    logic [15:0]      word_val;
    logic [9:0]       param_pos;
    logic [7:0]       param_d;
    logic [8:0]       nbytes;

    assign disc_bits = DISC_RST[DISCRETE_COUNT-1:0];
    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);

    mbs_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign store_byte = (frame_len_reg < LEN_W'(FRAME_BYTES));
    assign ram_we     = accept && store_byte;
    assign ram_waddr  = frame_len_reg[BUF_AW-1:0];
    assign crc_byte   = crc_add(rx_crc_reg, req.rx_byte);
    assign stored_len = store_byte ? frame_len_reg + 1'b1 : frame_len_reg;

    assign addr_f   = {hdr_reg[2], hdr_reg[3]};
    assign qty_f    = {hdr_reg[4], hdr_reg[5]};
    assign a_plus_q = {1'b0, addr_f} + {1'b0, qty_f};

    assign param_pos = 10'(PARAM_BASE) + {4'b0, cnt_reg};
    assign param_d   = zero_reg ? 8'h00 : ram_rdata;

    always_comb
    begin
        ram_raddr = BUF_AW'(cnt_reg);
        if (state_reg == ST_WR_RD)
            ram_raddr = param_pos[BUF_AW-1:0];
    end

    // bit position and remaining count for packed coil or discrete bytes (reads and multiple writes)
    always_comb
    begin
        if (state_reg == ST_EMIT)
            m_idx = cnt_reg - CNT_W'(3);
        else
            m_idx = cnt_reg;
        bit_p   = addr_f[7:0] + {m_idx[4:0], 3'b000};
        bit_rem = {1'b0, qty_f[7:0]} - {m_idx, 3'b000};
        for (int t = 0; t < 8; t++)
            bit_mask[t] = (9'(t) < bit_rem);
    end

    assign coil_wide = {8'h00, coil_reg} >> bit_p;
    assign disc_wide = {8'h00, disc_bits} >> bit_p;
    assign bits_byte = (src_reg ? disc_wide[7:0] : coil_wide[7:0]) & bit_mask;
    assign nbytes    = ({1'b0, qty_f[7:0]} + 9'd7) >> 3;

    always_comb
    begin
        word_idx = {2'b00, addr_f[3:0]} + {1'b0, m_idx[5:1]};
        word_val = 16'h0000;
        if (src_reg) begin
            if (word_idx < 6'(INPUT_REG_COUNT))
                word_val = (word_idx < 6'd3) ? INPUT_INIT[word_idx[1:0]] : 16'h0000;
        end
        else begin
            if (word_idx < 6'(HOLDING_COUNT))
                word_val = hold_reg[word_idx[HR_AW-1:0]];
        end
    end

    always_comb
    begin
        body_byte = 8'h00;
        case (kind_reg)
            RSP_EXC:
            begin
                case (cnt_reg)
                    6'd0:    body_byte = hdr_reg[0];
                    6'd1:    body_byte = hdr_reg[1] | EXC_FLAG;
                    default: body_byte = code_reg;
                endcase
            end
            RSP_ECHO:
            begin
                if (cnt_reg < 6'(HDR_BYTES))
                    body_byte = hdr_reg[cnt_reg[2:0]];
            end
            RSP_BITS:
            begin
                case (cnt_reg)
                    6'd0:    body_byte = hdr_reg[0];
                    6'd1:    body_byte = hdr_reg[1];
                    6'd2:    body_byte = nbytes[7:0];
                    default: body_byte = bits_byte;
                endcase
            end
            RSP_WORDS:
            begin
                case (cnt_reg)
                    6'd0:    body_byte = hdr_reg[0];
                    6'd1:    body_byte = hdr_reg[1];
                    6'd2:    body_byte = {qty_f[6:0], 1'b0};
                    default: body_byte = m_idx[0] ? word_val[7:0] : word_val[15:8];
                endcase
            end
            default: body_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        frame_len_next = frame_len_reg;
        rx_crc_next    = rx_crc_reg;
        crc_ok_next    = crc_ok_reg;
        hdr_we         = 1'b0;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        code_next      = code_reg;
        blen_next      = blen_reg;
        src_next       = src_reg;
        fn_next        = fn_reg;
        wtot_next      = wtot_reg;
        tx_crc_next    = tx_crc_reg;
        hi_next        = hi_reg;
        zero_next      = zero_reg;
        coil_we        = 1'b0;
        coil_p         = bit_p;
        coil_mask      = bit_mask;
        coil_d         = param_d;
        hold_we        = 1'b0;
        hold_idx       = word_idx;
        hold_d         = {hi_reg, param_d};
        rsp_valid      = 1'b0;
        rsp.tx_byte    = body_byte;
        rsp.last_byte  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (store_byte) begin
                        frame_len_next = stored_len;
                        rx_crc_next    = crc_byte;
                    end
                    if (req.end_of_frame) begin
                        frame_len_next = '0;
                        rx_crc_next    = CRC_INIT;
                        crc_ok_next    = store_byte ? (crc_byte == 16'h0000)
                                                    : (rx_crc_reg == 16'h0000);
                        cnt_next       = '0;
                        if (stored_len >= LEN_W'(MIN_FRAME))
                            state_next = ST_HDR_RD;
                    end
                end
            end
            ST_HDR_RD:
            begin
                state_next = ST_HDR_CAP;
            end
            ST_HDR_CAP:
            begin
                hdr_we = 1'b1;
                if (cnt_reg == CNT_W'(HDR_BYTES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
                else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_HDR_RD;
                end
            end
            ST_DECIDE:
            begin
                cnt_next    = '0;
                tx_crc_next = CRC_INIT;
                fn_next     = hdr_reg[1];
                kind_next   = RSP_EXC;
                blen_next   = CNT_W'(3);
                state_next  = ST_EMIT;
                src_next    = 1'b0;
                wtot_next   = '0;
                if (!crc_ok_reg || hdr_reg[0] != slave_address_reg) begin
                    code_next = EXC_DEVICE_FAILURE;
                end
                else begin
                    case (hdr_reg[1])
                        FN_READ_COILS, FN_READ_DISCRETE:
                        begin
                            src_next = (hdr_reg[1] == FN_READ_DISCRETE);
                            if (addr_f >= 16'((hdr_reg[1] == FN_READ_DISCRETE) ?
                                              DISCRETE_COUNT : COIL_COUNT) ||
                                a_plus_q > 17'((hdr_reg[1] == FN_READ_DISCRETE) ?
                                               DISCRETE_COUNT : COIL_COUNT))
                                code_next = EXC_ILLEGAL_ADDRESS;
                            else begin
                                kind_next = RSP_BITS;
                                blen_next = CNT_W'(nbytes) + CNT_W'(3);
                            end
                        end
                        FN_READ_HOLDING, FN_READ_INPUT:
                        begin
                            src_next = (hdr_reg[1] == FN_READ_INPUT);
                            if (addr_f >= 16'((hdr_reg[1] == FN_READ_INPUT) ?
                                              INPUT_REG_COUNT : HOLDING_COUNT) ||
                                a_plus_q > 17'((hdr_reg[1] == FN_READ_INPUT) ?
                                               INPUT_REG_COUNT : HOLDING_COUNT))
                                code_next = EXC_ILLEGAL_ADDRESS;
                            else begin
                                kind_next = RSP_WORDS;
                                blen_next = {qty_f[4:0], 1'b0} + CNT_W'(3);
                            end
                        end
                        FN_WRITE_COIL:
                        begin
                            if (addr_f >= 16'(COIL_COUNT))
                                code_next = EXC_ILLEGAL_ADDRESS;
                            else if (qty_f != COIL_ON && qty_f != COIL_OFF)
                                code_next = EXC_ILLEGAL_VALUE;
                            else begin
                                coil_we   = 1'b1;
                                coil_p    = addr_f[7:0];
                                coil_mask = 8'h01;
                                coil_d    = {7'b0, (qty_f == COIL_ON)};
                                kind_next = RSP_ECHO;
                                blen_next = CNT_W'(HDR_BYTES);
                            end
                        end
                        FN_WRITE_REG:
                        begin
                            if (addr_f >= 16'(HOLDING_COUNT))
                                code_next = EXC_ILLEGAL_ADDRESS;
                            else begin
                                hold_we   = 1'b1;
                                hold_idx  = {2'b00, addr_f[3:0]};
                                hold_d    = qty_f;
                                kind_next = RSP_ECHO;
                                blen_next = CNT_W'(HDR_BYTES);
                            end
                        end
                        FN_WRITE_COILS, FN_WRITE_REGS:
                        begin
                            if (addr_f >= 16'((hdr_reg[1] == FN_WRITE_REGS) ?
                                              HOLDING_COUNT : COIL_COUNT) ||
                                a_plus_q > 17'((hdr_reg[1] == FN_WRITE_REGS) ?
                                               HOLDING_COUNT : COIL_COUNT))
                                code_next = EXC_ILLEGAL_ADDRESS;
                            else begin
                                kind_next = RSP_ECHO;
                                blen_next = CNT_W'(HDR_BYTES);
                                if (hdr_reg[1] == FN_WRITE_REGS)
                                    wtot_next = {qty_f[4:0], 1'b0};
                                else
                                    wtot_next = CNT_W'(nbytes);
                                if (qty_f != 16'h0000)
                                    state_next = ST_WR_RD;
                            end
                        end
                        default: code_next = EXC_ILLEGAL_FUNCTION;
                    endcase
                end
            end
            ST_WR_RD:
            begin
                zero_next  = (param_pos >= 10'(FRAME_BYTES));
                state_next = ST_WR_DO;
            end
            ST_WR_DO:
            begin
                if (fn_reg == FN_WRITE_REGS) begin
                    if (!cnt_reg[0])
                        hi_next = param_d;
                    else
                        hold_we = 1'b1;
                end
                else begin
                    coil_we = 1'b1;
                end
                if (cnt_reg + 1'b1 == wtot_reg) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_WR_RD;
                end
            end
            ST_EMIT:
            begin
                rsp_valid   = 1'b1;
                tx_crc_next = crc_add(tx_crc_reg, body_byte);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == blen_reg)
                    state_next = ST_CRC_LO;
            end
            ST_CRC_LO:
            begin
                rsp_valid   = 1'b1;
                rsp.tx_byte = tx_crc_reg[7:0];
                state_next  = ST_CRC_HI;
            end
            ST_CRC_HI:
            begin
                rsp_valid     = 1'b1;
                rsp.tx_byte   = tx_crc_reg[15:8];
                rsp.last_byte = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= ST_IDLE;
            slave_address_reg <= 8'h01;
            frame_len_reg     <= '0;
            rx_crc_reg        <= CRC_INIT;
            crc_ok_reg        <= 1'b0;
            cnt_reg           <= '0;
            kind_reg          <= RSP_EXC;
            blen_reg          <= '0;
            wtot_reg          <= '0;
        end
        else begin
            state_reg     <= state_next;
            frame_len_reg <= frame_len_next;
            rx_crc_reg    <= rx_crc_next;
            crc_ok_reg    <= crc_ok_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            blen_reg      <= blen_next;
            wtot_reg      <= wtot_next;
            if (cfg_we)
                slave_address_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        src_reg    <= src_next;
        fn_reg     <= fn_next;
        tx_crc_reg <= tx_crc_next;
        hi_reg     <= hi_next;
        zero_reg   <= zero_next;
        if (hdr_we)
            hdr_reg[cnt_reg[2:0]] <= ram_rdata;
    end

    // data stores: coils and holding registers come out of reset with their preset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            coil_reg <= COIL_RST[COIL_COUNT-1:0];
            for (int i = 0; i < HOLDING_COUNT; i++)
                hold_reg[i] <= (i < 5) ? HOLDING_INIT[i] : 16'h0000;
        end
        else begin
            if (coil_we)
                coil_reg <= COIL_COUNT'((({8'h00, coil_reg} &
                                          ~({{COIL_COUNT{1'b0}}, coil_mask} << coil_p)) |
                                         ({{COIL_COUNT{1'b0}}, coil_d & coil_mask} << coil_p)));
            if (hold_we && hold_idx < 6'(HOLDING_COUNT))
                hold_reg[hold_idx[HR_AW-1:0]] <= hold_d;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) rsp_valid |-> busy)
        else $error("response strobe outside a busy period");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (rsp_valid && rsp.last_byte) |=> !busy)
        else $error("engine still busy after final response byte");

    assert property (@(posedge clk) disable iff (!rst_n)
                     frame_len_reg <= LEN_W'(FRAME_BYTES))
        else $error("frame length beyond buffer size");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_EMIT) |-> (cnt_reg < blen_reg))
        else $error("response body index past body length");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mbs_pkg::*;

    localparam int NCOIL = COIL_COUNT_DEF;
    localparam int NDISC = DISCRETE_COUNT_DEF;
    localparam int NIREG = INPUT_REG_COUNT_DEF;
    localparam int NHREG = HOLDING_COUNT_DEF;
    localparam int NBUF  = FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    mbs_req_t req;
    logic     cfg_we;
    logic [7:0] cfg_wdata;
    logic     rsp_valid;
    mbs_rsp_t rsp;

    modbus_rtu_slave_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // slave model state
    logic [7:0]  unit_addr;
    logic [7:0]  rx_buf [NBUF];
    int          rx_len;
    logic [15:0] rx_crc;
    logic        coils [NCOIL];
    logic        discs [NDISC];
    logic [15:0] in_regs [NIREG];
    logic [15:0] hold_regs [NHREG];
    logic [7:0]  reply [$];

    mbs_rsp_t    pending_replies [$];
    mbs_req_t    tx_queue [$];
    logic [7:0]  cur_addr;
    int          errors;
    int          frames_sent;
    int          reply_bytes;
    int          exceptions_seen;
    int          cycles;
    logic        taken;

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] buf_at(int i);
        return (i < NBUF) ? rx_buf[i] : 8'h00;
    endfunction

    function automatic void seal_reply();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (reply[i])
            c = crc16_step(c, reply[i]);
        reply.push_back(c[7:0]);
        reply.push_back(c[15:8]);
    endfunction

    function automatic void reply_exception(logic [7:0] code);
        reply.delete();
        reply.push_back(buf_at(0));
        reply.push_back(buf_at(1) | EXC_FLAG);
        reply.push_back(code);
        seal_reply();
    endfunction

    function automatic void reply_echo();
        reply.delete();
        for (int i = 0; i < HDR_BYTES; i++)
            reply.push_back(buf_at(i));
        seal_reply();
    endfunction

    function automatic bit range_bad(int a, int q, int cnt);
        return a >= cnt || a + q > cnt;
    endfunction

    function automatic void reply_bits(bit is_coil, int cnt, int a, int q);
        logic [7:0] acc;
        logic       b;
        if (range_bad(a, q, cnt))
        begin
            reply_exception(EXC_ILLEGAL_ADDRESS);
            return;
        end
        reply.delete();
        reply.push_back(buf_at(0));
        reply.push_back(buf_at(1));
        reply.push_back(8'((q + 7) / 8));
        acc = '0;
        for (int i = 0; i < q; i++)
        begin
            b = is_coil ? coils[a + i] : discs[a + i];
            if (b)
                acc[i % 8] = 1'b1;
            if (i % 8 == 7 || i + 1 == q)
            begin
                reply.push_back(acc);
                acc = '0;
            end
        end
        seal_reply();
    endfunction

    function automatic void reply_words(bit is_hold, int cnt, int a, int q);
        logic [15:0] w;
        if (range_bad(a, q, cnt))
        begin
            reply_exception(EXC_ILLEGAL_ADDRESS);
            return;
        end
        reply.delete();
        reply.push_back(buf_at(0));
        reply.push_back(buf_at(1));
        reply.push_back(8'(q * 2));
        for (int i = 0; i < q; i++)
        begin
            w = is_hold ? hold_regs[a + i] : in_regs[a + i];
            reply.push_back(w[15:8]);
            reply.push_back(w[7:0]);
        end
        seal_reply();
    endfunction

    function automatic void run_frame();
        logic [7:0] fn;
        logic [7:0] pb;
        int a;
        int q;
        fn = buf_at(1);
        a = {buf_at(2), buf_at(3)};
        q = {buf_at(4), buf_at(5)};
        if (rx_crc != 16'h0000 || buf_at(0) != unit_addr)
        begin
            reply_exception(EXC_DEVICE_FAILURE);
            return;
        end
        case (fn)
            FN_READ_COILS:    reply_bits(1'b1, NCOIL, a, q);
            FN_READ_DISCRETE: reply_bits(1'b0, NDISC, a, q);
            FN_READ_HOLDING:  reply_words(1'b1, NHREG, a, q);
            FN_READ_INPUT:    reply_words(1'b0, NIREG, a, q);
            FN_WRITE_COIL:
            begin
                if (a >= NCOIL)
                    reply_exception(EXC_ILLEGAL_ADDRESS);
                else if (q == COIL_ON || q == COIL_OFF)
                begin
                    coils[a] = (q == COIL_ON);
                    reply_echo();
                end
                else
                    reply_exception(EXC_ILLEGAL_VALUE);
            end
            FN_WRITE_REG:
            begin
                if (a >= NHREG)
                    reply_exception(EXC_ILLEGAL_ADDRESS);
                else
                begin
                    hold_regs[a] = q[15:0];
                    reply_echo();
                end
            end
            FN_WRITE_COILS:
            begin
                if (range_bad(a, q, NCOIL))
                    reply_exception(EXC_ILLEGAL_ADDRESS);
                else
                begin
                    for (int i = 0; i < q; i++)
                    begin
                        pb = buf_at(PARAM_BASE + i / 8);
                        coils[a + i] = pb[i % 8];
                    end
                    reply_echo();
                end
            end
            FN_WRITE_REGS:
            begin
                if (range_bad(a, q, NHREG))
                    reply_exception(EXC_ILLEGAL_ADDRESS);
                else
                begin
                    for (int i = 0; i < q; i++)
                        hold_regs[a + i] = {buf_at(PARAM_BASE + 2 * i),
                                            buf_at(PARAM_BASE + 1 + 2 * i)};
                    reply_echo();
                end
            end
            default: reply_exception(EXC_ILLEGAL_FUNCTION);
        endcase
    endfunction

    function automatic void take_byte(mbs_req_t r);
        mbs_rsp_t e;
        if (rx_len < NBUF)
        begin
            rx_buf[rx_len] = r.rx_byte;
            rx_len++;
            rx_crc = crc16_step(rx_crc, r.rx_byte);
        end
        if (!r.end_of_frame)
            return;
        reply.delete();
        if (rx_len >= MIN_FRAME)
            run_frame();
        if (reply.size() > 1 && reply[1][7])
            exceptions_seen++;
        foreach (reply[k])
        begin
            e.tx_byte = reply[k];
            e.last_byte = (k == reply.size() - 1);
            pending_replies.push_back(e);
        end
        rx_len = 0;
        rx_crc = CRC_INIT;
    endfunction

    // monitor: check replies, then update the model with the accepted request
    always @(posedge clk)
    begin
        mbs_rsp_t e;
        if (rst_n)
        begin
            if (rsp_valid)
            begin
                reply_bytes++;
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reply byte, expected none, actual %02h/%0b",
                             $time, rsp.tx_byte, rsp.last_byte);
                end
                else
                begin
                    e = pending_replies.pop_front();
                    if (rsp.tx_byte !== e.tx_byte || rsp.last_byte !== e.last_byte)
                    begin
                        errors++;
                        $display("%0t: reply mismatch, expected %02h/%0b, actual %02h/%0b",
                                 $time, e.tx_byte, e.last_byte, rsp.tx_byte, rsp.last_byte);
                    end
                end
            end
            if (cfg_we)
                unit_addr = cfg_wdata;
            if (start && !busy)
                take_byte(req);
        end
        taken <= rst_n && start && !busy;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // driver: one request per accept, random gaps between them
    int gap_left;
    always @(negedge clk)
    begin
        mbs_req_t nxt;
        logic     nstart;
        nxt = req;
        nstart = start;
        if (rst_n && (!start || taken))
        begin
            nstart = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (tx_queue.size() > 0)
            begin
                nxt = tx_queue.pop_front();
                nstart = 1'b1;
                gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            end
        end
        start <= nstart;
        req <= nxt;
    end

    task automatic queue_frame(input logic [7:0] body [$], input bit crc_ok);
        logic [15:0] c;
        mbs_req_t r;
        c = CRC_INIT;
        foreach (body[i])
            c = crc16_step(c, body[i]);
        if (!crc_ok)
            c = c ^ 16'(1 << $urandom_range(0, 15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            r.rx_byte = body[i];
            r.end_of_frame = (i == body.size() - 1);
            tx_queue.push_back(r);
        end
        frames_sent++;
    endtask

    task automatic queue_cmd(input logic [7:0] addr, input logic [7:0] fn,
                             input logic [15:0] a, input logic [15:0] q, input bit crc_ok);
        logic [7:0] body [$];
        int nb;
        body = '{addr, fn, a[15:8], a[7:0], q[15:8], q[7:0]};
        if (fn == FN_WRITE_COILS || fn == FN_WRITE_REGS)
        begin
            nb = (fn == FN_WRITE_COILS) ? (int'(q) + 7) / 8 : 2 * int'(q);
            body.push_back(8'(nb));
            for (int i = 0; i < nb; i++)
                body.push_back(8'($urandom));
        end
        queue_frame(body, crc_ok);
    endtask

    task automatic queue_noise(input int len, input bit eof_last);
        mbs_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.rx_byte = 8'($urandom);
            r.end_of_frame = eof_last && (i == len - 1);
            tx_queue.push_back(r);
        end
    endtask

    task automatic queue_random_request();
        logic [7:0] fns [8];
        logic [7:0] fn, addr;
        logic [15:0] a, q;
        logic [7:0] body [$];
        int cnt, pick, cut;
        fns = '{FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING, FN_READ_INPUT,
                FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS};
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            queue_noise($urandom_range(1, 10), 1'b1);
            return;
        end
        fn = (pick < 10) ? 8'($urandom) : fns[$urandom_range(0, 7)];
        case (fn)
            FN_READ_COILS, FN_WRITE_COIL, FN_WRITE_COILS: cnt = NCOIL;
            FN_READ_DISCRETE: cnt = NDISC;
            FN_READ_INPUT:    cnt = NIREG;
            default:          cnt = NHREG;
        endcase
        a = 16'($urandom_range(0, cnt - 1));
        q = 16'($urandom_range(0, cnt - int'(a)));
        if ($urandom_range(0, 9) == 0)
        begin
            a = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, cnt));
            q = 16'($urandom_range(0, cnt + 2));
        end
        if (fn == FN_WRITE_COIL)
            case ($urandom_range(0, 4))
                0, 1: q = COIL_ON;
                2, 3: q = COIL_OFF;
                default: q = 16'($urandom);
            endcase
        else if (fn == FN_WRITE_REG)
            q = 16'($urandom);
        addr = ($urandom_range(0, 14) == 0) ? 8'($urandom) : cur_addr;
        if ($urandom_range(0, 19) == 0)
        begin
            // truncated but CRC-valid: missing parameters come from older frames
            body = '{addr, fn, a[15:8], a[7:0], q[15:8], q[7:0]};
            cut = $urandom_range(2, 5);
            while (body.size() > cut)
                void'(body.pop_back());
            queue_frame(body, 1'b1);
        end
        else
            queue_cmd(addr, fn, a, q, $urandom_range(0, 14) != 0);
    endtask

    task automatic drain_and_idle();
        while (tx_queue.size() != 0 || start || pending_replies.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic set_unit_addr(input logic [7:0] v);
        drain_and_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_addr = v;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] addrs [4];
        logic [7:0] body [$];
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = 8'h00;
        gap_left = 0;
        errors = 0;
        frames_sent = 0;
        reply_bytes = 0;
        exceptions_seen = 0;
        cycles = 0;
        unit_addr = 8'd1;
        cur_addr = 8'd1;
        rx_len = 0;
        rx_crc = CRC_INIT;
        foreach (rx_buf[i]) rx_buf[i] = 8'h00;
        foreach (coils[i]) coils[i] = (i == 1 || i == 6 || i == 11 || i == 16);
        foreach (discs[i]) discs[i] = (i == 0 || i == 4 || i == 9);
        foreach (in_regs[i]) in_regs[i] = INPUT_INIT[i];
        foreach (hold_regs[i]) hold_regs[i] = HOLDING_INIT[i];
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the low buffer positions so later short frames never hit unwritten bytes
        queue_noise(20, 1'b1);
        queue_cmd(8'd1, FN_READ_COILS, 16'd0, 16'(NCOIL), 1'b1);
        queue_cmd(8'd1, FN_READ_DISCRETE, 16'd0, 16'(NDISC), 1'b1);
        queue_cmd(8'd1, FN_READ_HOLDING, 16'd0, 16'(NHREG), 1'b1);
        queue_cmd(8'd1, FN_READ_INPUT, 16'd2, 16'd0, 1'b1);
        queue_cmd(8'd1, FN_WRITE_COIL, 16'd19, COIL_ON, 1'b1);
        queue_cmd(8'd1, FN_WRITE_COIL, 16'd3, 16'h1234, 1'b1);
        queue_cmd(8'd1, FN_WRITE_COIL, 16'd20, COIL_OFF, 1'b1);
        queue_cmd(8'd1, FN_WRITE_REG, 16'd4, 16'hFFFF, 1'b1);
        queue_cmd(8'd1, FN_WRITE_COILS, 16'd0, 16'd20, 1'b1);
        queue_cmd(8'd1, FN_WRITE_REGS, 16'd0, 16'd5, 1'b1);
        queue_cmd(8'd1, FN_READ_HOLDING, 16'd4, 16'd2, 1'b1);
        queue_cmd(8'd1, FN_READ_INPUT, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_cmd(8'd1, 8'h07, 16'd0, 16'd1, 1'b1);
        queue_cmd(8'd1, FN_READ_COILS, 16'd0, 16'd1, 1'b0);
        queue_cmd(8'd2, FN_READ_COILS, 16'd0, 16'd1, 1'b1);
        queue_cmd(8'd0, FN_WRITE_REG, 16'd0, 16'd0, 1'b1);
        queue_noise(3, 1'b1);
        // oversized frame: bytes past the buffer are ignored
        body = '{8'd1, FN_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01};
        queue_frame(body, 1'b1);
        queue_noise(NBUF + 4, 1'b1);

        addrs = '{8'd247, 8'($urandom_range(2, 246)), 8'd1, 8'd128};
        foreach (addrs[p])
        begin
            set_unit_addr(addrs[p]);
            queue_random_request();
            drain_and_idle();
            repeat (2)
            begin
                queue_random_request();
                while (tx_queue.size() > 40) @(negedge clk);
            end
        end

        drain_and_idle();
        $display("Sent %0d frames covering all functions, exceptions, short, long and", frames_sent);
        $display("truncated frames over 4 unit addresses: %0d reply bytes, %0d exceptions",
                 reply_bytes, exceptions_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
